@@ hw/rtl/vps_pkg.sv @@
// Shared types, constants and helpers for the vertex projection pipeline.
package vps_pkg;

    // Register map
    localparam int REG_COUNT = 6;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    localparam logic [2:0] REG_COEF_X_A = 3'd0;
    localparam logic [2:0] REG_COEF_X_B = 3'd1;
    localparam logic [2:0] REG_COEF_Y_A = 3'd2;
    localparam logic [2:0] REG_COEF_Y_B = 3'd3;
    localparam logic [2:0] REG_COEF_Z_A = 3'd4;
    localparam logic [2:0] REG_COEF_Z_B = 3'd5;

    // Arithmetic constants
    localparam logic signed [63:0] DEPTH_BIAS   = 64'sd196608;
    localparam logic signed [63:0] SCREEN_SCALE = 64'sd240;
    localparam logic signed [63:0] SCREEN_OFF_X = 64'sd20971520;
    localparam logic signed [63:0] SCREEN_OFF_Y = 64'sd15728640;
    localparam int FIX_SHIFT = 16;
    localparam int W_FRAC    = 28;

    // Reciprocal divider: 2^44 / |d| for |d| above 2^13 fits in 31 bits.
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = 16;
    localparam int QUO_W      = DIV_STEP * DIV_STAGES;
    localparam logic [31:0] SMALL_DEN = 32'd8192;
    localparam logic [31:0] REM_INIT  = 32'd4096;

    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;

    typedef logic [DATA_W-1:0] t_coef [REG_COUNT];

    typedef struct packed {
        logic signed [31:0] xt;
        logic signed [31:0] yt;
        logic signed [31:0] zt;
    } t_view;

    typedef struct packed {
        logic signed [31:0] xt;
        logic signed [31:0] yt;
        logic signed [31:0] w;
        logic               fault;
    } t_proj;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(INT_MAX)) begin
            r = INT_MAX;
        end else if (v < 64'(INT_MIN)) begin
            r = INT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/vps_transform.sv @@
// Affine row transform: input register, product stage and row-sum stage.
module vps_transform (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  vps_pkg::t_coef        i_coef,
    output logic                  o_valid,
    output vps_pkg::t_view        o_view
);
    import vps_pkg::*;

    logic               r_v0, r_v1, r_v2;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [63:0] r_prod [9];
    logic signed [31:0] r_tr [3];
    t_view              r_view;
    logic signed [31:0] n_row [3];

    // Valid bits follow the data through the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        r_px <= i_pos_x;
        r_py <= i_pos_y;
        r_pz <= i_pos_z;
    end

    // Nine exact 32x32 products, one per matrix coefficient, with the three translations registered alongside.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_prod[3*r]   <= $signed(i_coef[2*r][31:0])    * r_px;
            r_prod[3*r+1] <= $signed(i_coef[2*r][63:32])   * r_py;
            r_prod[3*r+2] <= $signed(i_coef[2*r+1][31:0])  * r_pz;
            r_tr[r]       <= $signed(i_coef[2*r+1][63:32]);
        end
    end

    // Floor-shift each product, add the translation and clamp.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_row[r] = sat32((r_prod[3*r] >>> FIX_SHIFT) + (r_prod[3*r+1] >>> FIX_SHIFT)
                             + (r_prod[3*r+2] >>> FIX_SHIFT) + 64'(r_tr[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_view.xt <= n_row[0];
        r_view.yt <= n_row[1];
        r_view.zt <= n_row[2];
    end

    assign o_valid = r_v2;
    assign o_view  = r_view;

endmodule

@@ hw/rtl/vps_recip.sv @@
// Depth bias and pipelined reciprocal: w = 2^44 / (z' + 3), clamped.
module vps_recip (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vps_pkg::t_view  i_view,
    output logic            o_valid,
    output vps_pkg::t_proj  o_proj
);
    import vps_pkg::*;

    typedef struct packed {
        logic signed [31:0] xt;
        logic signed [31:0] yt;
        logic               neg;
        logic               tiny;
        logic               zero;
    } t_side;

    logic              r_vld  [DIV_STAGES+1];
    logic [31:0]       r_rem  [DIV_STAGES+1];
    logic [31:0]       r_den  [DIV_STAGES+1];
    logic [QUO_W-1:0]  r_quo  [DIV_STAGES+1];
    t_side             r_side [DIV_STAGES+1];
    logic signed [31:0] n_d;
    logic [31:0]       n_mag;
    logic              r_out_v;
    t_proj             r_proj;
    logic signed [31:0] n_w;

    // Entry stage: biased denominator, its magnitude and the special cases.
    always_comb begin
        n_d   = sat32(64'(i_view.zt) + DEPTH_BIAS);
        n_mag = n_d[31] ? 32'(-n_d) : n_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]        <= REM_INIT;
        r_den[0]        <= n_mag;
        r_quo[0]        <= '0;
        r_side[0].xt    <= i_view.xt;
        r_side[0].yt    <= i_view.yt;
        r_side[0].neg   <= n_d[31];
        r_side[0].tiny  <= (n_mag <= SMALL_DEN);
        r_side[0].zero  <= (n_d == 32'sd0);
    end

    // Restoring division, DIV_STEP quotient bits per stage.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [31:0]         rem_n;
        logic [DIV_STEP-1:0] qb_n;

        always_comb begin
            logic [32:0] t;
            rem_n = r_rem[g];
            qb_n  = '0;
            for (int b = DIV_STEP - 1; b >= 0; b--) begin
                t = {rem_n, 1'b0};
                if (t >= {1'b0, r_den[g]}) begin
                    t       = t - {1'b0, r_den[g]};
                    qb_n[b] = 1'b1;
                end
                rem_n = t[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= rem_n;
            r_den[g+1]  <= r_den[g];
            r_quo[g+1]  <= {r_quo[g][QUO_W-1-DIV_STEP:0], qb_n};
            r_side[g+1] <= r_side[g];
        end
    end

    // Apply the sign, the clamp for small denominators and zero for a zero denominator.
    always_comb begin
        if (r_side[DIV_STAGES].zero) begin
            n_w = 32'sd0;
        end else if (r_side[DIV_STAGES].tiny) begin
            n_w = r_side[DIV_STAGES].neg ? INT_MIN : INT_MAX;
        end else if (r_side[DIV_STAGES].neg) begin
            n_w = $signed(32'(-r_quo[DIV_STAGES]));
        end else begin
            n_w = $signed(r_quo[DIV_STAGES][31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_proj.xt    <= r_side[DIV_STAGES].xt;
        r_proj.yt    <= r_side[DIV_STAGES].yt;
        r_proj.w     <= n_w;
        r_proj.fault <= r_side[DIV_STAGES].zero;
    end

    assign o_valid = r_out_v;
    assign o_proj  = r_proj;

endmodule

@@ hw/rtl/vps_screen.sv @@
// Perspective scaling by w and viewport mapping to screen pixels.
module vps_screen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  vps_pkg::t_proj     i_proj,
    output logic               o_valid,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    output logic signed [31:0] o_inv_depth,
    output logic               o_depth_fault
);
    import vps_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic signed [63:0] r_mx, r_my;
    logic signed [31:0] r_w1, r_w2;
    logic               r_f1, r_f2;
    logic signed [31:0] r_xs, r_ys;
    logic signed [31:0] r_sx, r_sy, r_wo;
    logic               r_fo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Multiply the view coordinates by w.
    always_ff @(posedge i_clk) begin
        r_mx <= i_proj.xt * i_proj.w;
        r_my <= i_proj.yt * i_proj.w;
        r_w1 <= i_proj.w;
        r_f1 <= i_proj.fault;
    end

    // Back to Q16.16 with a floor shift and clamp.
    always_ff @(posedge i_clk) begin
        r_xs <= sat32(r_mx >>> W_FRAC);
        r_ys <= sat32(r_my >>> W_FRAC);
        r_w2 <= r_w1;
        r_f2 <= r_f1;
    end

    // Viewport map; a zero denominator forces the coordinate and depth fields to zero.
    always_ff @(posedge i_clk) begin
        r_sx <= r_f2 ? 32'sd0 : sat32(64'(r_xs) * SCREEN_SCALE + SCREEN_OFF_X);
        r_sy <= r_f2 ? 32'sd0 : sat32(64'(r_ys) * SCREEN_SCALE + SCREEN_OFF_Y);
        r_wo <= r_f2 ? 32'sd0 : r_w2;
        r_fo <= r_f2;
    end

    assign o_valid       = r_v3;
    assign o_screen_x    = r_sx;
    assign o_screen_y    = r_sy;
    assign o_inv_depth   = r_wo;
    assign o_depth_fault = r_fo;

endmodule

@@ hw/rtl/vertex_project_to_screen_unit.sv @@
// Top level of the vertex projection unit: register file and pipeline.
//
// Projects one vertex per clock. A request is taken whenever start is high;
// busy is never raised. Each result appears for one cycle with o_valid
// high and cannot be held off. The pipeline consists of the reciprocal
// divider, which resolves two quotient bits in each of its 16 stages, plus
// three transform stages and five stages around the divider. The six 64-bit
// coefficient registers sit at byte addresses 8*i; the user must write them
// only while no request is in flight, as the block itself does not enforce it.
module vertex_project_to_screen_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  logic signed [31:0]         i_pos_z,
    output logic                       o_valid,
    output logic signed [31:0]         o_screen_x,
    output logic signed [31:0]         o_screen_y,
    output logic signed [31:0]         o_inv_depth,
    output logic                       o_depth_fault,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vps_pkg::ADDR_W-1:0] paddr,
    input  logic [vps_pkg::DATA_W-1:0] pwdata,
    output logic [vps_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import vps_pkg::*;

    t_coef       r_coef;
    logic [2:0]  cfg_idx;
    logic        cfg_wr;
    logic        xf_valid, rc_valid;
    t_view       xf_view;
    t_proj       rc_proj;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    // Coefficient registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_coef[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COEF_X_A: r_coef[0] <= pwdata;
                REG_COEF_X_B: r_coef[1] <= pwdata;
                REG_COEF_Y_A: r_coef[2] <= pwdata;
                REG_COEF_Y_B: r_coef[3] <= pwdata;
                REG_COEF_Z_A: r_coef[4] <= pwdata;
                REG_COEF_Z_B: r_coef[5] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (cfg_idx)
            REG_COEF_X_A: prdata = r_coef[0];
            REG_COEF_X_B: prdata = r_coef[1];
            REG_COEF_Y_A: prdata = r_coef[2];
            REG_COEF_Y_B: prdata = r_coef[3];
            REG_COEF_Z_A: prdata = r_coef[4];
            REG_COEF_Z_B: prdata = r_coef[5];
            default:      prdata = '0;
        endcase
    end

    vps_transform u_transform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_coef  (r_coef),
        .o_valid (xf_valid),
        .o_view  (xf_view)
    );

    vps_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xf_valid),
        .i_view  (xf_view),
        .o_valid (rc_valid),
        .o_proj  (rc_proj)
    );

    vps_screen u_screen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (rc_valid),
        .i_proj        (rc_proj),
        .o_valid       (o_valid),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_inv_depth   (o_inv_depth),
        .o_depth_fault (o_depth_fault)
    );

`ifndef SYNTHESIS
    // A faulted result carries all-zero coordinate and depth fields.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_depth_fault |->
            o_screen_x == 32'sd0 && o_screen_y == 32'sd0 && o_inv_depth == 32'sd0)
        else $error("faulted result with nonzero fields");

    // A good denominator never yields a zero reciprocal.
    a_w_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_depth_fault |-> o_inv_depth != 32'sd0)
        else $error("zero reciprocal without depth fault");

    // The divider pipeline only advances requests that entered it.
    a_div_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rc_valid |-> $past(xf_valid, DIV_STAGES + 2))
        else $error("divider output without a matching request");
`endif

endmodule
